[rtl/core/isc_pkg.sv]
package isc_pkg;

    // Filter dimensions and fixed-point format.
    localparam int SECTIONS       = 4;
    localparam int TAPS           = 5;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 24;

    // Field and storage widths.
    localparam int ACTION_W  = 2;
    localparam int SECIDX_W  = 2;
    localparam int TAPIDX_W  = 3;
    localparam int COEF_W    = 32;
    localparam int HIST_W    = 32;
    localparam int ACTIVE_W  = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Derived sizes.
    localparam int DEPTH     = SECTIONS * TAPS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int TAP_W     = $clog2(TAPS);
    localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(2 * TAPS) + 1;
    localparam int RES_W     = ACC_W - COEF_FRAC_BITS;

    // Rounding constant: one half at the coefficient scale.
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_FILTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NUM    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEN    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    // Configuration register indexes.
    localparam logic [PADDR_W-3:0] REG_ACTIVE = 1'b0;

endpackage

[rtl/core/isc_if.sv]
// Input item channel.
interface isc_in_if;
    import isc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [SECIDX_W-1:0]        section_index;
    logic [TAPIDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (
        output valid, action, section_index, tap_index, coef_value, sample_in,
        input  ready
    );
    modport sink (
        input  valid, action, section_index, tap_index, coef_value, sample_in,
        output ready
    );
endinterface

// Result item channel.
interface isc_out_if;
    import isc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    modport source (
        output valid, sample_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, sample_out, saturated,
        output ready
    );
endinterface

[rtl/core/iir_section_cascade_core.sv]
// Operation: for each active section, one shared multiplier walks the numerator and
// denominator taps over one coefficient and one history RAM, through the states START,
// NUM and DEN for each tap, FIN1 and FIN2; the result item then waits in OUT. A new item is
// taken only in the idle state, so a filter item completes before the next item is accepted;
// coefficient writes and clears are taken without leaving the idle state.
// Reset: active_sections returns to 1, and per-entry valid bits make all coefficients and
// histories read as zero at once; no clearing pass is needed.
module iir_section_cascade_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    isc_in_if.sink                     i_in,
    isc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [isc_pkg::PADDR_W-1:0] paddr,
    input  logic [isc_pkg::PDATA_W-1:0] pwdata,
    output logic [isc_pkg::PDATA_W-1:0] prdata,
    output logic                       pready
);
    import isc_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_DEN   = 3'd3;
    localparam logic [2:0] ST_FIN1  = 3'd4;
    localparam logic [2:0] ST_FIN2  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Coefficient RAM holds {denominator, numerator}; history RAM holds {output, input}.
    logic [2*COEF_W-1:0] coef_mem [DEPTH];
    logic [2*HIST_W-1:0] hist_mem [DEPTH];

    logic [DEPTH-1:0]    r_cvn;
    logic [DEPTH-1:0]    r_cvd;
    logic [DEPTH-1:0]    r_hv;

    logic [2*COEF_W-1:0] r_coef_q;
    logic [2*HIST_W-1:0] r_hist_q;
    logic                r_cvn_q;
    logic                r_cvd_q;
    logic                r_hv_q;

    logic [2:0]          r_state;
    logic [ACTIVE_W-1:0] r_active;
    logic [TAP_W-1:0]    r_tap;
    logic [SEC_W-1:0]    r_sec;
    logic [SEC_W-1:0]    r_last;
    logic [ADDR_W-1:0]   r_base;

    logic signed [HIST_W-1:0] r_x;
    logic signed [HIST_W-1:0] r_prev_i;
    logic signed [HIST_W-1:0] r_prev_o;
    logic signed [HIST_W-1:0] r_ih_old;
    logic signed [HIST_W-1:0] r_oh_old;
    logic signed [COEF_W-1:0] r_den;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;

    logic                     in_acc;
    logic                     out_load;
    logic                     cfg_wr;
    logic                     cw_num;
    logic                     cw_den;
    logic [ADDR_W-1:0]        cw_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     hw_en;
    logic [ADDR_W-1:0]        hw_addr;
    logic [2*HIST_W-1:0]      hw_data;
    logic signed [COEF_W-1:0] num_q;
    logic signed [COEF_W-1:0] den_q;
    logic signed [HIST_W-1:0] ih_q;
    logic signed [HIST_W-1:0] oh_q;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [RES_W-1:0]  res;
    logic                     y_clip;
    logic signed [HIST_W-1:0] y;
    logic                     x_clip;
    logic signed [SAMPLE_BITS-1:0] x_sat;
    logic [SEC_W-1:0]         n_last;
    logic [ACTIVE_W:0]        act_ext;
    logic                     wr_ok;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[PADDR_W-1:2] == REG_ACTIVE);
    assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE) ?
                    PDATA_W'(r_active) : '0;

    // Handshakes.
    assign i_in.ready       = (r_state == ST_IDLE);
    assign in_acc           = i_in.valid && i_in.ready;
    assign out_load         = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    // Coefficient writes land directly from an accepted item when in range.
    assign wr_ok   = (32'(i_in.section_index) < SECTIONS) && (32'(i_in.tap_index) < TAPS);
    assign cw_num  = in_acc && (i_in.action == ACT_NUM) && wr_ok;
    assign cw_den  = in_acc && (i_in.action == ACT_DEN) && wr_ok;
    assign cw_addr = ADDR_W'(i_in.section_index) * ADDR_W'(TAPS) + ADDR_W'(i_in.tap_index);

    // Clamp the section count to the valid range, kept as the last section index.
    always_comb begin
        act_ext = {1'b0, r_active};
        if (act_ext == '0) begin
            n_last = '0;
        end else if (32'(act_ext) > SECTIONS) begin
            n_last = SEC_W'(SECTIONS - 1);
        end else begin
            n_last = SEC_W'(act_ext - 1'b1);
        end
    end

    // Read address: tap zero at section start, the next tap during the denominator cycle.
    assign rd_en   = (r_state == ST_START) ||
                     ((r_state == ST_DEN) && (r_tap != TAP_W'(TAPS - 1)));
    assign rd_addr = (r_state == ST_START) ? r_base :
                     r_base + ADDR_W'(r_tap) + ADDR_W'(1);

    // Entries that were never written read as zero.
    assign num_q = r_cvn_q ? r_coef_q[COEF_W-1:0]        : '0;
    assign den_q = r_cvd_q ? r_coef_q[2*COEF_W-1:COEF_W] : '0;
    assign ih_q  = r_hv_q  ? r_hist_q[HIST_W-1:0]        : '0;
    assign oh_q  = r_hv_q  ? r_hist_q[2*HIST_W-1:HIST_W] : '0;

    // Accumulate the product from the previous cycle.
    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = r_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);

    // Round half up, drop the fraction and saturate to the history width.
    always_comb begin
        rnd    = r_acc + RND_HALF;
        res    = RES_W'(rnd >>> COEF_FRAC_BITS);
        y_clip = !((&res[RES_W-1:HIST_W-1]) || !(|res[RES_W-1:HIST_W-1]));
        if (y_clip) begin
            y = rnd[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
        end else begin
            y = res[HIST_W-1:0];
        end
    end

    // Final saturation to the sample width.
    always_comb begin
        x_clip = !((&r_x[HIST_W-1:SAMPLE_BITS-1]) || !(|r_x[HIST_W-1:SAMPLE_BITS-1]));
        if (x_clip) begin
            x_sat = r_x[HIST_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            x_sat = r_x[SAMPLE_BITS-1:0];
        end
    end

    // History write: shifted entries during the walk, the newest pair at the end.
    always_comb begin
        hw_en   = 1'b0;
        hw_addr = r_base + ADDR_W'(r_tap);
        hw_data = {r_prev_o, r_prev_i};
        if ((r_state == ST_NUM) && (r_tap != '0)) begin
            hw_en = 1'b1;
        end else if (r_state == ST_FIN2) begin
            hw_en   = 1'b1;
            hw_addr = r_base;
            hw_data = {y, r_x};
        end
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (cw_num) begin
            coef_mem[cw_addr][COEF_W-1:0] <= i_in.coef_value;
        end
        if (cw_den) begin
            coef_mem[cw_addr][2*COEF_W-1:COEF_W] <= i_in.coef_value;
        end
        if (hw_en) begin
            hist_mem[hw_addr] <= hw_data;
        end
        if (rd_en) begin
            r_coef_q <= coef_mem[rd_addr];
            r_hist_q <= hist_mem[rd_addr];
            r_cvn_q  <= r_cvn[rd_addr];
            r_cvd_q  <= r_cvd[rd_addr];
            r_hv_q   <= r_hv[rd_addr];
        end
    end

    // Control state, valid bits and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= ACTIVE_W'(1);
            r_cvn       <= '0;
            r_cvd       <= '0;
            r_hv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_active <= pwdata[ACTIVE_W-1:0];
            end
            if (cw_num) begin
                r_cvn[cw_addr] <= 1'b1;
            end
            if (cw_den) begin
                r_cvd[cw_addr] <= 1'b1;
            end
            if (in_acc && (i_in.action == ACT_CLEAR)) begin
                r_hv <= '0;
            end else if (hw_en) begin
                r_hv[hw_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.action == ACT_FILTER)) begin
                        r_state <= ST_START;
                    end
                end
                ST_START: r_state <= ST_NUM;
                ST_NUM:   r_state <= ST_DEN;
                ST_DEN: begin
                    if (r_tap == TAP_W'(TAPS - 1)) begin
                        r_state <= ST_FIN1;
                    end else begin
                        r_state <= ST_NUM;
                    end
                end
                ST_FIN1: r_state <= ST_FIN2;
                ST_FIN2: begin
                    if (r_sec == r_last) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_START;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: one shared multiplier and a wide accumulator.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in.action == ACT_FILTER)) begin
                    r_x    <= HIST_W'(i_in.sample_in);
                    r_sec  <= '0;
                    r_base <= '0;
                    r_last <= n_last;
                    r_sat  <= 1'b0;
                end
            end
            ST_START: begin
                r_acc    <= '0;
                r_prod   <= '0;
                r_sub    <= 1'b0;
                r_tap    <= '0;
                r_prev_i <= r_x;
                r_prev_o <= '0;
            end
            ST_NUM: begin
                r_acc    <= n_acc;
                r_prod   <= num_q * r_prev_i;
                r_sub    <= 1'b0;
                r_den    <= den_q;
                r_ih_old <= ih_q;
                r_oh_old <= oh_q;
            end
            ST_DEN: begin
                r_acc    <= n_acc;
                // Denominator tap zero takes no part in the sum.
                if (r_tap == '0) begin
                    r_prod <= '0;
                end else begin
                    r_prod <= r_den * r_prev_o;
                end
                r_sub    <= 1'b1;
                r_prev_i <= r_ih_old;
                r_prev_o <= r_oh_old;
                if (r_tap != TAP_W'(TAPS - 1)) begin
                    r_tap <= r_tap + TAP_W'(1);
                end
            end
            ST_FIN1: begin
                r_acc <= n_acc;
            end
            ST_FIN2: begin
                r_x   <= y;
                r_sat <= r_sat | y_clip;
                if (r_sec != r_last) begin
                    r_sec  <= r_sec + SEC_W'(1);
                    r_base <= r_base + ADDR_W'(TAPS);
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out_sample <= x_sat;
                    r_out_sat    <= r_sat | x_clip;
                end
            end
            default: ;
        endcase
    end

endmodule

[verif/isc_cascade_checker.sv]
// Watches both item channels and the register port, predicts every filtered sample
// and compares each result item with the oldest prediction still waiting.
module isc_cascade_checker
    import isc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    isc_in_if                  in_ch,
    isc_out_if                 out_ch,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    // The accumulator is wide enough to hold the sum of all products exactly.
    localparam int SUM_W = 2 * COEF_W + 16;
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] WORD_MAX = (SUM_W'(1) << (HIST_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] WORD_MIN = ~WORD_MAX;
    localparam logic signed [HIST_W-1:0] OUT_MAX =
        (HIST_W'(1) << (SAMPLE_BITS - 1)) - HIST_W'(1);
    localparam logic signed [HIST_W-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE, 2'b00};
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   clipped;
    } filter_result_t;

    // Private copy of the coefficient store, the histories and the register.
    logic signed [COEF_W-1:0] num_taps [SECTIONS][TAPS];
    logic signed [COEF_W-1:0] den_taps [SECTIONS][TAPS];
    logic signed [HIST_W-1:0] x_hist [SECTIONS][TAPS];
    logic signed [HIST_W-1:0] y_hist [SECTIONS][TAPS];
    logic [ACTIVE_W-1:0]      active_cfg;
    filter_result_t           pending_samples [$];

    // Runs one sample through the active sections and updates their histories.
    function automatic filter_result_t run_cascade(input logic signed [SAMPLE_BITS-1:0] x_in);
        logic signed [SUM_W-1:0]  sum;
        logic signed [HIST_W-1:0] stage;
        int                       n;
        filter_result_t           r;
        if (active_cfg == 0) begin
            n = 1;
        end else if (active_cfg > SECTIONS) begin
            n = SECTIONS;
        end else begin
            n = int'(active_cfg);
        end
        stage = HIST_W'(x_in);
        r.clipped = 1'b0;
        for (int s = 0; s < n; s++) begin
            for (int t = TAPS - 1; t > 0; t--) x_hist[s][t] = x_hist[s][t-1];
            x_hist[s][0] = stage;
            sum = '0;
            for (int t = 0; t < TAPS; t++) sum = sum + num_taps[s][t] * x_hist[s][t];
            // Denominator tap zero is never used.
            for (int t = 1; t < TAPS; t++) sum = sum - den_taps[s][t] * y_hist[s][t-1];
            sum = (sum + HALF_LSB) >>> COEF_FRAC_BITS;
            if (sum > WORD_MAX) begin
                sum = WORD_MAX;
                r.clipped = 1'b1;
            end else if (sum < WORD_MIN) begin
                sum = WORD_MIN;
                r.clipped = 1'b1;
            end
            for (int t = TAPS - 1; t > 0; t--) y_hist[s][t] = y_hist[s][t-1];
            y_hist[s][0] = sum[HIST_W-1:0];
            stage = sum[HIST_W-1:0];
        end
        // The last active section is clipped once more to the sample width.
        if (stage > OUT_MAX) begin
            stage = OUT_MAX;
            r.clipped = 1'b1;
        end else if (stage < OUT_MIN) begin
            stage = OUT_MIN;
            r.clipped = 1'b1;
        end
        r.sample = stage[SAMPLE_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        filter_result_t want;
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                for (int t = 0; t < TAPS; t++) begin
                    num_taps[s][t] = '0;
                    den_taps[s][t] = '0;
                    x_hist[s][t] = '0;
                    y_hist[s][t] = '0;
                end
            end
            active_cfg = ACTIVE_W'(1);
            pending_samples.delete();
            o_fail_count = 0;
            o_results = 0;
            o_clipped = 0;
        end else begin
            // Register writes land at the access cycle.
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ACTIVE_ADDR) begin
                active_cfg = i_pwdata[ACTIVE_W-1:0];
            end

            // Compare each result item with the oldest prediction.
            if (out_ch.valid && out_ch.ready) begin
                if (pending_samples.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result item: sample_out %0d saturated %0b",
                                 $time, $signed(out_ch.sample_out), out_ch.saturated);
                    end
                end else begin
                    want = pending_samples.pop_front();
                    o_results++;
                    if (want.clipped) o_clipped++;
                    if (out_ch.sample_out !== want.sample) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                     $time, $signed(want.sample), $signed(out_ch.sample_out));
                        end
                    end
                    if (out_ch.saturated !== want.clipped) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                                     $time, want.clipped, out_ch.saturated);
                        end
                    end
                end
            end

            // Update the private state for each accepted input item.
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.action)
                    ACT_FILTER: begin
                        pending_samples.push_back(run_cascade(in_ch.sample_in));
                    end
                    ACT_NUM: begin
                        if (in_ch.section_index < SECTIONS && in_ch.tap_index < TAPS) begin
                            num_taps[in_ch.section_index][in_ch.tap_index] = in_ch.coef_value;
                        end
                    end
                    ACT_DEN: begin
                        if (in_ch.section_index < SECTIONS && in_ch.tap_index < TAPS) begin
                            den_taps[in_ch.section_index][in_ch.tap_index] = in_ch.coef_value;
                        end
                    end
                    ACT_CLEAR: begin
                        for (int s = 0; s < SECTIONS; s++) begin
                            for (int t = 0; t < TAPS; t++) begin
                                x_hist[s][t] = '0;
                                y_hist[s][t] = '0;
                            end
                        end
                    end
                endcase
            end
        end
        o_pending = pending_samples.size();
    end

endmodule

[verif/tb_top.sv]
// Drives coefficient loads, clears and sample items into the filter cascade, stalls the
// result side at random and reports the verdict from the checker's failure count.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import isc_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD = 1500;
    localparam int PHASE_ITEMS = 90;
    localparam longint WATCHDOG_NS = 4_000_000;
    localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE, 2'b00};

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int results_seen;
    int clipped_seen;
    int items_sent;
    int settings_done;
    bit sender_burst;

    // Section counts per phase, including the clamped values 0, 6 and 7.
    logic [ACTIVE_W-1:0] phase_sections [8] = '{ACTIVE_W'(4), ACTIVE_W'(0), ACTIVE_W'(2),
                                                 ACTIVE_W'(7), ACTIVE_W'(3), ACTIVE_W'(1),
                                                 ACTIVE_W'(6), ACTIVE_W'(4)};

    isc_in_if  in_ch ();
    isc_out_if out_ch ();

    iir_section_cascade_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    isc_cascade_checker cascade_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_clipped    (clipped_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers one item after a random gap and returns at the edge that accepts it.
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [SECIDX_W-1:0] sec,
                             input logic [TAPIDX_W-1:0] tap,
                             input logic signed [COEF_W-1:0] coef,
                             input logic signed [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.section_index <= sec;
        in_ch.tap_index <= tap;
        in_ch.coef_value <= coef;
        in_ch.sample_in <= smp;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Waits until every predicted sample has come back and the block has settled.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the section count register with a setup and an access cycle.
    task automatic write_active(input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ACTIVE_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random coefficient in the range -span..span.
    function automatic logic signed [COEF_W-1:0] random_coef(input int span);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Half of the samples are full range, the rest stay small.
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        if ($urandom_range(0, 1) == 1) begin
            return SAMPLE_BITS'($urandom);
        end
        return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    // Result side: random stalls, stretches without stalls and two long hold-offs.
    initial begin : result_receiver
        int  hold;
        int  taken;
        bit  burst;
        out_ch.ready = 1'b0;
        taken = 0;
        burst = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            hold = burst ? 0 : $urandom_range(0, 19);
            if (taken == 150 || taken == 600) hold = LONG_HOLD;
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge clk);
            while (!out_ch.valid) @(negedge clk);
            @(posedge clk);
            taken++;
        end
    end

    initial begin : stimulus
        logic [PDATA_W-1:0] cfg_word;
        int                 pick;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_FILTER;
        in_ch.section_index = '0;
        in_ch.tap_index = '0;
        in_ch.coef_value = '0;
        in_ch.sample_in = '0;
        items_sent = 0;
        settings_done = 0;
        sender_burst = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with one active section: zero store, identity, clipping in both
        // directions, ignored writes, unused denominator tap zero, clear and rounding.
        send_item(ACT_FILTER, '0, '0, '0, SMP_MAX);
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(0), COEF_ONE, '0);
        send_item(ACT_FILTER, '0, '0, '0, SMP_MAX);
        send_item(ACT_FILTER, '0, '0, '0, SMP_MIN);
        send_item(ACT_DEN, SECIDX_W'(0), TAPIDX_W'(0), COEF_MAX, '0);
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(12345));
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(7), COEF_MAX, '0);
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(5), COEF_MIN, '0);
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(-1));
        send_item(ACT_DEN, SECIDX_W'(0), TAPIDX_W'(1), -COEF_HALF, '0);
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(1000));
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(0));
        send_item(ACT_CLEAR, '0, '0, '0, '0);
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(0));
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(0), COEF_MAX, '0);
        send_item(ACT_FILTER, '0, '0, '0, SMP_MAX);
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(0), COEF_MIN, '0);
        send_item(ACT_FILTER, '0, '0, '0, SMP_MAX);
        send_item(ACT_NUM, SECIDX_W'(3), TAPIDX_W'(4), COEF_ONE, '0);
        send_item(ACT_DEN, SECIDX_W'(0), TAPIDX_W'(1), '0, '0);
        send_item(ACT_CLEAR, '0, '0, '0, '0);
        send_item(ACT_NUM, SECIDX_W'(0), TAPIDX_W'(0), COEF_HALF, '0);
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(1));
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(-1));
        send_item(ACT_FILTER, '0, '0, '0, SAMPLE_BITS'(3));
        drain_block();

        // Random phases, each under its own section count and a fresh coefficient set.
        for (int p = 0; p < $size(phase_sections); p++) begin
            cfg_word = $urandom;
            cfg_word[ACTIVE_W-1:0] = phase_sections[p];
            write_active(cfg_word);
            settings_done++;
            sender_burst = ($urandom_range(0, 3) == 0);

            // Mild taps keep most sections stable, so samples mostly pass unclipped.
            for (int s = 0; s < SECTIONS; s++) begin
                for (int t = 0; t < TAPS; t++) begin
                    send_item(ACT_NUM, SECIDX_W'(s), TAPIDX_W'(t), random_coef(1 << 23),
                              SAMPLE_BITS'($urandom));
                end
                for (int t = 1; t < TAPS; t++) begin
                    send_item(ACT_DEN, SECIDX_W'(s), TAPIDX_W'(t), random_coef(1 << 21),
                              SAMPLE_BITS'($urandom));
                end
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    send_item(ACT_FILTER, SECIDX_W'($urandom), TAPIDX_W'($urandom),
                              COEF_W'($urandom), random_sample());
                end else if (pick < 80) begin
                    send_item(ACT_NUM, SECIDX_W'($urandom),
                              TAPIDX_W'($urandom_range(0, TAPS - 1)),
                              random_coef(1 << 23), SAMPLE_BITS'($urandom));
                end else if (pick < 88) begin
                    send_item(ACT_DEN, SECIDX_W'($urandom),
                              TAPIDX_W'($urandom_range(0, TAPS - 1)),
                              random_coef(1 << 21), SAMPLE_BITS'($urandom));
                end else if (pick < 91) begin
                    send_item(ACT_CLEAR, SECIDX_W'($urandom), TAPIDX_W'($urandom),
                              COEF_W'($urandom), SAMPLE_BITS'($urandom));
                end else begin
                    // Noise: any action, tap indexes past the store, full-range values.
                    send_item(ACTION_W'($urandom), SECIDX_W'($urandom), TAPIDX_W'($urandom),
                              COEF_W'($urandom), SAMPLE_BITS'($urandom));
                end
            end
            drain_block();
        end

        $display("Sent %0d items over %0d section settings from 0 to 7 after a directed part.",
                 items_sent, settings_done);
        $display("Checked %0d filtered samples, %0d of them clipped.",
                 results_seen, clipped_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Ends a hung run.
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Timeout with %0d predicted samples still waiting.", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
